// ----- rtl/assert_macros.svh -----
// Shared assertion macros. Every check is clocked on the rising edge and
// is switched off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/ubrio_pkg.sv -----
package ubrio_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index, taken from paddr bit 2 and up
  localparam logic REG_QUIET_MODE = 1'b0;

  localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
  localparam logic [3:0] HEX_NINE       = 4'd9;

  typedef enum logic [1:0] {
    REQ_POLL = 2'd0,
    REQ_PUT  = 2'd1,
    REQ_HEX  = 2'd2,
    REQ_GET  = 2'd3
  } req_t;

  typedef struct packed {
    logic capture;  // latch item, issue ring reads
    logic step1;    // main operation (or first hex digit)
    logic step2;    // second hex digit
    logic finish;   // load result register
  } ubrio_cmd_t;

  typedef struct packed {
    req_t req;
  } ubrio_sts_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    logic [7:0] w;
    w = {4'b0, n};
    return (n <= HEX_NINE) ? w + HEX_DIGIT_BASE : w + HEX_ALPHA_BASE;
  endfunction

endpackage

// ----- rtl/ubrio_ctrl.sv -----
module ubrio_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ubrio_pkg::ubrio_sts_t sts,
  output ubrio_pkg::ubrio_cmd_t cmd
);
  import ubrio_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_HEX2 = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result slot can take a new item this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.req == REQ_HEX) begin
          cmd.step1 = 1'b1;
          state_nxt = ST_HEX2;
        end else if (out_free) begin
          cmd.step1  = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_HEX2: begin
        if (out_free) begin
          cmd.step2  = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/ubrio_dp.sv -----
module ubrio_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ubrio_pkg::ubrio_cmd_t cmd,
  output ubrio_pkg::ubrio_sts_t sts,
  input  logic                  quiet_we,
  input  logic                  quiet_wdata,
  output logic                  quiet_mode,
  input  logic [1:0]            req_type,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            line_rx_byte,
  input  logic                  line_rx_full,
  input  logic                  line_overrun,
  input  logic                  line_framing_error,
  input  logic                  line_tx_empty,
  output logic                  res_line_tx_valid,
  output logic [7:0]            res_line_tx_byte,
  output logic                  res_got_valid,
  output logic [7:0]            res_got_byte,
  output logic                  res_rx_available,
  output logic [7:0]            res_errors_seen,
  output logic                  res_tx_busy
);
  import ubrio_pkg::*;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  // latched item
  req_t       req_r;
  logic [7:0] data_r, rxb_r;
  logic       rxfull_r, ovr_r, fe_r, txempty_r;

  logic [7:0] rx_rdata_r, tx_rdata_r;

  logic [RX_AW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt, rx_wr_inc, rx_rd_inc;
  logic [TX_AW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt, tx_wr_inc, tx_rd_inc;
  logic [7:0]       err_r, err_nxt;
  logic             act_r, act_nxt;
  logic             quiet_r;

  logic       rx_we, tx_we;
  logic [7:0] tx_wdata;
  logic       txv, gv;
  logic [7:0] txb, gb;

  assign sts.req    = req_r;
  assign quiet_mode = quiet_r;

  assign rx_wr_inc = (rx_wr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_r + 1'b1;
  assign rx_rd_inc = (rx_rd_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_r + 1'b1;
  assign tx_wr_inc = (tx_wr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;

  always_comb begin
    err_nxt   = err_r;
    rx_wr_nxt = rx_wr_r;
    rx_rd_nxt = rx_rd_r;
    tx_wr_nxt = tx_wr_r;
    tx_rd_nxt = tx_rd_r;
    act_nxt   = act_r;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    tx_wdata  = hex_ascii(data_r[7:4]);
    txv       = 1'b0;
    txb       = 8'h00;
    gv        = 1'b0;
    gb        = 8'h00;
    if (cmd.step1) begin
      case (req_r)
        REQ_POLL: begin
          err_nxt = err_r + {7'b0, ovr_r} + {7'b0, fe_r};
          if (!fe_r && rxfull_r) begin
            rx_we     = 1'b1;
            rx_wr_nxt = rx_wr_inc;
          end
          if (txempty_r) begin
            if ((tx_wr_r != tx_rd_r) && !quiet_r) begin
              txv       = 1'b1;
              txb       = tx_rdata_r;
              tx_rd_nxt = tx_rd_inc;
              act_nxt   = 1'b1;
            end else begin
              act_nxt = 1'b0;
            end
          end
        end
        REQ_PUT: begin
          tx_we     = 1'b1;
          tx_wdata  = data_r;
          tx_wr_nxt = tx_wr_inc;
        end
        REQ_HEX: begin
          tx_we     = 1'b1;
          tx_wr_nxt = tx_wr_inc;
        end
        REQ_GET: begin
          if (rx_wr_r != rx_rd_r) begin
            gv        = 1'b1;
            gb        = rx_rdata_r;
            rx_rd_nxt = rx_rd_inc;
          end
        end
        default: ;
      endcase
    end else if (cmd.step2) begin
      tx_we     = 1'b1;
      tx_wdata  = hex_ascii(data_r[3:0]);
      tx_wr_nxt = tx_wr_inc;
    end
  end

  // rings: reads are issued when the item is latched, indices are settled then
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_r] <= rxb_r;
    end
    if (cmd.capture) begin
      rx_rdata_r <= rx_mem[rx_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wr_r] <= tx_wdata;
    end
    if (cmd.capture) begin
      tx_rdata_r <= tx_mem[tx_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_t'(req_type);
      data_r    <= data_byte;
      rxb_r     <= line_rx_byte;
      rxfull_r  <= line_rx_full;
      ovr_r     <= line_overrun;
      fe_r      <= line_framing_error;
      txempty_r <= line_tx_empty;
    end
    if (cmd.finish) begin
      res_line_tx_valid <= txv;
      res_line_tx_byte  <= txb;
      res_got_valid     <= gv;
      res_got_byte      <= gb;
      res_rx_available  <= (rx_wr_nxt != rx_rd_nxt);
      res_errors_seen   <= err_nxt;
      res_tx_busy       <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_r <= '0;
      rx_rd_r <= '0;
      tx_wr_r <= '0;
      tx_rd_r <= '0;
      err_r   <= '0;
      act_r   <= 1'b0;
      quiet_r <= 1'b0;
    end else begin
      rx_wr_r <= rx_wr_nxt;
      rx_rd_r <= rx_rd_nxt;
      tx_wr_r <= tx_wr_nxt;
      tx_rd_r <= tx_rd_nxt;
      err_r   <= err_nxt;
      act_r   <= act_nxt;
      if (quiet_we) begin
        quiet_r <= quiet_wdata;
      end
    end
  end

endmodule

// ----- rtl/uart_buffered_ring_io.sv -----
// Buffered UART glue: a 64-byte receive ring and a 64-byte transmit ring
// between software requests and a polled UART line.
// Input channel (in_valid / in_stall): one request item per handshake:
// poll the line, put a byte, put a byte as two ASCII hex digits, or get.
// Result channel (out_valid / out_stall): exactly one result item per
// request, carrying the line transmit byte, the popped byte, ring status,
// the line error count and the transmit busy flag.
// The result is registered: a taken request passes through ST_EXEC
// (then ST_HEX2 for hex-put) into the result register. The next
// request is taken only once the current one has loaded its result;
// the ring memories' registered read port sets the ST_EXEC step, and
// hex-put's second digit takes a second write on the transmit ring.
// A new item is taken while an earlier result still waits; the block
// then holds it in ST_EXEC or ST_HEX2 until the result register frees.
// Reset (rst_n low, synchronous) empties both rings, clears the error
// count, the busy flag and quiet mode. Ring contents are not cleared.
// APB register 0 (address 0): bit 0 quiet_mode, stops draining the
// transmit ring. Neither ring checks for full; overflow loses data.
module uart_buffered_ring_io (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ubrio_pkg::CFG_AW-1:0]  paddr,
  input  logic [ubrio_pkg::CFG_DW-1:0]  pwdata,
  output logic [ubrio_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_data_byte,
  input  logic [7:0]                    in_line_rx_byte,
  input  logic                          in_line_rx_full,
  input  logic                          in_line_overrun,
  input  logic                          in_line_framing_error,
  input  logic                          in_line_tx_empty,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_line_tx_valid,
  output logic [7:0]                    out_line_tx_byte,
  output logic                          out_got_valid,
  output logic [7:0]                    out_got_byte,
  output logic                          out_rx_available,
  output logic [7:0]                    out_errors_seen,
  output logic                          out_tx_busy
);
  import ubrio_pkg::*;

  ubrio_cmd_t cmd;
  ubrio_sts_t sts;
  logic       quiet_we, quiet_mode, sel_quiet;

  assign pready    = 1'b1;
  assign sel_quiet = (paddr[CFG_AW-1:2] == {(CFG_AW-2){REG_QUIET_MODE}});
  assign quiet_we  = psel && penable && pwrite && pready && sel_quiet;
  assign prdata    = sel_quiet ? {{(CFG_DW-1){1'b0}}, quiet_mode} : '0;

  ubrio_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ubrio_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .quiet_we           (quiet_we),
    .quiet_wdata        (pwdata[0]),
    .quiet_mode         (quiet_mode),
    .req_type           (in_req_type),
    .data_byte          (in_data_byte),
    .line_rx_byte       (in_line_rx_byte),
    .line_rx_full       (in_line_rx_full),
    .line_overrun       (in_line_overrun),
    .line_framing_error (in_line_framing_error),
    .line_tx_empty      (in_line_tx_empty),
    .res_line_tx_valid  (out_line_tx_valid),
    .res_line_tx_byte   (out_line_tx_byte),
    .res_got_valid      (out_got_valid),
    .res_got_byte       (out_got_byte),
    .res_rx_available   (out_rx_available),
    .res_errors_seen    (out_errors_seen),
    .res_tx_busy        (out_tx_busy)
  );

endmodule

// ----- rtl/ubrio_chk.sv -----
`include "assert_macros.svh"

module ubrio_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_line_tx_valid,
  input logic [7:0] out_line_tx_byte,
  input logic       out_got_valid,
  input logic [7:0] out_got_byte,
  input logic       out_tx_busy
);

  // a stalled result stays up
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // no line byte without a send
  `ASSERT_IMPL(a_tx_byte_zero, clk, rst_n, out_valid && !out_line_tx_valid, out_line_tx_byte == 8'h00)

  // no popped byte without a hit
  `ASSERT_IMPL(a_got_byte_zero, clk, rst_n, out_valid && !out_got_valid, out_got_byte == 8'h00)

  // a send always leaves the transmitter busy
  `ASSERT_IMPL(a_send_busy, clk, rst_n, out_valid && out_line_tx_valid, out_tx_busy)

endmodule

bind uart_buffered_ring_io ubrio_chk u_ubrio_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_line_tx_valid (out_line_tx_valid),
  .out_line_tx_byte  (out_line_tx_byte),
  .out_got_valid     (out_got_valid),
  .out_got_byte      (out_got_byte),
  .out_tx_busy       (out_tx_busy)
);

// ----- tb/uart_buffered_ring_io_test.sv -----
module uart_buffered_ring_io_test;
  import ubrio_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int DIR_ROWS    = 24;
  localparam int MAX_REPORTS = 40;
  localparam int DRAIN_WAIT  = 8;
  localparam logic [CFG_AW-1:0] QUIET_ADDR = {REG_QUIET_MODE, 2'b00};

  typedef struct packed {
    req_t       req;
    logic [7:0] data;
    logic [7:0] rx_byte;
    logic       rx_full;
    logic       overrun;
    logic       framing;
    logic       tx_empty;
  } uart_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       got_valid;
    logic [7:0] got_byte;
    logic       rx_avail;
    logic [7:0] errors;
    logic       tx_busy;
  } uart_result_t;

  typedef struct packed {
    uart_req_t    req;
    logic         typed;
    uart_result_t res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_req_type;
  logic [7:0]          in_data_byte;
  logic [7:0]          in_line_rx_byte;
  logic                in_line_rx_full;
  logic                in_line_overrun;
  logic                in_line_framing_error;
  logic                in_line_tx_empty;
  logic                out_valid;
  logic                out_stall;
  logic                out_line_tx_valid;
  logic [7:0]          out_line_tx_byte;
  logic                out_got_valid;
  logic [7:0]          out_got_byte;
  logic                out_rx_available;
  logic [7:0]          out_errors_seen;
  logic                out_tx_busy;

  uart_buffered_ring_io dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_data_byte          (in_data_byte),
    .in_line_rx_byte       (in_line_rx_byte),
    .in_line_rx_full       (in_line_rx_full),
    .in_line_overrun       (in_line_overrun),
    .in_line_framing_error (in_line_framing_error),
    .in_line_tx_empty      (in_line_tx_empty),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_line_tx_valid     (out_line_tx_valid),
    .out_line_tx_byte      (out_line_tx_byte),
    .out_got_valid         (out_got_valid),
    .out_got_byte          (out_got_byte),
    .out_rx_available      (out_rx_available),
    .out_errors_seen       (out_errors_seen),
    .out_tx_busy           (out_tx_busy)
  );

  // ring state mirrored by the predictor
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [RX_AW-1:0] rx_wr, rx_rd;
  logic [TX_AW-1:0] tx_wr, tx_rd;
  logic [7:0]       err_count;
  logic             busy_flag;
  logic             quiet_reg;

  uart_result_t pending_results[$];
  dir_row_t     dir_rows [DIR_ROWS];

  int fail_count;
  int report_count;
  int results_checked;
  int cycle_count;
  int req_count [4];
  int line_bytes, got_bytes, line_errors, rx_overruns, tx_overruns, quiet_writes;
  int gap_pct, stall_pct;
  bit no_idle;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    string digits;
    digits = "0123456789ABCDEF";
    return 8'(digits.getc(int'(n)));
  endfunction

  function automatic void tx_push(input logic [7:0] b);
    tx_mem[tx_wr] = b;
    tx_wr = tx_wr + 1'b1;
    if (tx_wr == tx_rd) tx_overruns++;
  endfunction

  function automatic uart_result_t uart_rings_step(input uart_req_t r);
    uart_result_t res;
    res = '0;
    case (r.req)
      REQ_POLL: begin
        if (r.overrun) begin
          err_count = err_count + 8'd1;
          line_errors++;
        end
        if (r.framing) begin
          err_count = err_count + 8'd1;
          line_errors++;
        end else if (r.rx_full) begin
          rx_mem[rx_wr] = r.rx_byte;
          rx_wr = rx_wr + 1'b1;
          if (rx_wr == rx_rd) rx_overruns++;
        end
        if (r.tx_empty) begin
          if (tx_wr != tx_rd && !quiet_reg) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_mem[tx_rd];
            tx_rd        = tx_rd + 1'b1;
            busy_flag    = 1'b1;
            line_bytes++;
          end else begin
            busy_flag = 1'b0;
          end
        end
      end
      REQ_PUT: tx_push(r.data);
      REQ_HEX: begin
        tx_push(hex_char(r.data[7:4]));
        tx_push(hex_char(r.data[3:0]));
      end
      default: begin
        if (rx_wr != rx_rd) begin
          res.got_valid = 1'b1;
          res.got_byte  = rx_mem[rx_rd];
          rx_rd         = rx_rd + 1'b1;
          got_bytes++;
        end
      end
    endcase
    res.rx_avail = (rx_wr != rx_rd);
    res.errors   = err_count;
    res.tx_busy  = busy_flag;
    return res;
  endfunction

  // profiles: 0 balanced, 1 filling rings, 2 draining rings, 3 noisy line
  function automatic uart_req_t make_item(input int profile);
    uart_req_t it;
    int poll_w, put_w, hex_w, txe_pct, rxf_pct, ovr_pct, frm_pct, pick;
    case (profile)
      1: begin
        poll_w = 50; put_w = 25; hex_w = 20; txe_pct = 10; rxf_pct = 90;
        ovr_pct = 5; frm_pct = 5;
      end
      2: begin
        poll_w = 50; put_w = 10; hex_w = 5; txe_pct = 85; rxf_pct = 30;
        ovr_pct = 5; frm_pct = 5;
      end
      3: begin
        poll_w = 70; put_w = 10; hex_w = 10; txe_pct = 50; rxf_pct = 70;
        ovr_pct = 50; frm_pct = 50;
      end
      default: begin
        poll_w = 40; put_w = 20; hex_w = 15; txe_pct = 50; rxf_pct = 60;
        ovr_pct = 8; frm_pct = 8;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < poll_w) it.req = REQ_POLL;
    else if (pick < poll_w + put_w) it.req = REQ_PUT;
    else if (pick < poll_w + put_w + hex_w) it.req = REQ_HEX;
    else it.req = REQ_GET;
    // line flags stay random on every request type; only polls look at them
    it.data     = 8'($urandom);
    it.rx_byte  = 8'($urandom);
    it.rx_full  = ($urandom_range(0, 99) < rxf_pct);
    it.overrun  = ($urandom_range(0, 99) < ovr_pct);
    it.framing  = ($urandom_range(0, 99) < frm_pct);
    it.tx_empty = ($urandom_range(0, 99) < txe_pct);
    return it;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("%0t: result %0d %s expected %h got %h", $time, results_checked,
                 name, want, got);
      end
    end
  endtask

  task automatic compare_result(input uart_result_t want, input uart_result_t got);
    report_field("line_tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
    report_field("line_tx_byte", want.tx_byte, got.tx_byte);
    report_field("got_valid", 8'(want.got_valid), 8'(got.got_valid));
    report_field("got_byte", want.got_byte, got.got_byte);
    report_field("rx_available", 8'(want.rx_avail), 8'(got.rx_avail));
    report_field("errors_seen", want.errors, got.errors);
    report_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_quiet_readback();
    logic [CFG_DW-1:0] rd;
    cfg_read(QUIET_ADDR, rd);
    if (rd !== CFG_DW'(quiet_reg)) begin
      fail_count++;
      $display("%0t: quiet_mode readback expected %h got %h", $time,
               CFG_DW'(quiet_reg), rd);
    end
  endtask

  task automatic set_quiet(input logic q);
    cfg_write(QUIET_ADDR, CFG_DW'(q));
    quiet_reg = q;
    quiet_writes++;
    check_quiet_readback();
  endtask

  task automatic send_request(input uart_req_t it);
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_req_type           <= it.req;
    in_data_byte          <= it.data;
    in_line_rx_byte       <= it.rx_byte;
    in_line_rx_full       <= it.rx_full;
    in_line_overrun       <= it.overrun;
    in_line_framing_error <= it.framing;
    in_line_tx_empty      <= it.tx_empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count[it.req]++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("uart_buffered_ring_io_test NOT OK");
    $finish;
  end

  // result side: check accepted items, stall in random bursts
  initial begin
    int unsigned  stall_left;
    uart_result_t got;
    uart_result_t want;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_line_tx_valid, out_line_tx_byte, out_got_valid, out_got_byte,
                out_rx_available, out_errors_seen, out_tx_busy};
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          compare_result(want, got);
          results_checked++;
        end
      end
      if (no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    uart_req_t    it;
    uart_result_t predicted;
    int           phase_profile [PHASES];
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_valid              = 1'b0;
    in_req_type           = REQ_POLL;
    in_data_byte          = '0;
    in_line_rx_byte       = '0;
    in_line_rx_full       = 1'b0;
    in_line_overrun       = 1'b0;
    in_line_framing_error = 1'b0;
    in_line_tx_empty      = 1'b0;
    rx_wr = '0; rx_rd = '0; tx_wr = '0; tx_rd = '0;
    err_count = '0; busy_flag = 1'b0; quiet_reg = 1'b0;
    fail_count = 0; report_count = 0; results_checked = 0;
    line_bytes = 0; got_bytes = 0; line_errors = 0;
    rx_overruns = 0; tx_overruns = 0; quiet_writes = 0;
    foreach (req_count[i]) req_count[i] = 0;
    gap_pct = 25; stall_pct = 25; no_idle = 1'b0;
    phase_profile = '{0, 1, 3, 2, 1, 3, 2, 0};

    // fields: req, data, rx byte, rx full, overrun, framing, tx empty;
    // then typed flag and result: tx valid/byte, got valid/byte, avail, errors, busy
    dir_rows = '{
      '{'{REQ_GET, 8'hAA, 8'h55, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
      '{'{REQ_POLL, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0}},
      '{'{REQ_POLL, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h02, 1'b0}},
      '{'{REQ_POLL, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 8'h03, 1'b0}},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 8'h03, 1'b0}},
      '{'{REQ_GET, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b1, 8'hFF, 1'b1, 8'h03, 1'b0}},
      '{'{REQ_GET, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 8'h03, 1'b0}},
      '{'{REQ_GET, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h03, 1'b0}},
      '{'{REQ_POLL, 8'h00, 8'h12, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_PUT, 8'h00, 8'h77, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_PUT, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_HEX, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_HEX, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_HEX, 8'h9A, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b1}},
      // transmitter still full: busy holds
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b1}},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h04, 1'b1}},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b1, 8'h30, 1'b0, 8'h00, 1'b0, 8'h04, 1'b1}},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
      // ring drained: busy drops
      '{'{REQ_POLL, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h04, 1'b0}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    check_quiet_readback();

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      predicted = uart_rings_step(dir_rows[i].req);
      pending_results.push_back(dir_rows[i].typed ? dir_rows[i].res : predicted);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_all_results();
      set_quiet(~phase[0]);
      gap_pct   = 20 * $urandom_range(0, 2);
      stall_pct = 20 * $urandom_range(0, 2);
      // the closing phase runs at full rate on both sides
      if (phase == PHASES - 1) no_idle = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = make_item(phase_profile[phase]);
        send_request(it);
        pending_results.push_back(uart_rings_step(it));
      end
    end

    wait_all_results();
    $display("Ran %0d polls, %0d puts, %0d hex puts, %0d gets; %0d results checked.",
             req_count[REQ_POLL], req_count[REQ_PUT], req_count[REQ_HEX],
             req_count[REQ_GET], results_checked);
    $display("%0d bytes to line, %0d got, %0d line errors, %0d/%0d rx/tx overruns, %0d quiet writes.",
             line_bytes, got_bytes, line_errors, rx_overruns, tx_overruns, quiet_writes);
    if (fail_count == 0) begin
      $display("uart_buffered_ring_io_test OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("uart_buffered_ring_io_test NOT OK");
    end
    $finish;
  end

endmodule
